// File: sv/rmst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared types and constants for the range maximum segment tree.
// ----------------------------------------------------------------------------
package rmst_pkg;

    // item field widths
    localparam int OP_BITS  = 2;
    localparam int POS_BITS = 10;
    localparam int VAL_W    = 16;

    // stream widths (tdata padded to whole bytes)
    localparam int S_TDATA_W = 40;  // position, range_end, leaf_value
    localparam int S_TUSER_W = OP_BITS;
    localparam int M_TDATA_W = 32;  // max_value, max_position
    localparam int M_TUSER_W = 1;   // found

    // parameter defaults
    localparam int LEAVES_DEF     = 1024;
    localparam int VALUE_BITS_DEF = 16;

    typedef enum logic [OP_BITS-1:0] {
        OP_CLEAR  = 2'd0,
        OP_UPDATE = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_UPD_LEAF,
        ST_UPD_WALK,
        ST_QRY_FIRST,
        ST_QRY_WALK,
        ST_QRY_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic sweep_step;
        logic load_upd;
        logic load_qry;
        logic upd_leaf;
        logic upd_walk;
        logic qry_first;
        logic qry_walk;
        logic out_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic sweep_last;
        logic upd_ok;
        logic qry_ok;
        logic upd_root;
        logic qry_more;
    } sts_t;

endpackage

// File: sv/rmst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmst_ctrl
// Sequencer for clear sweep, update walk and query walk; owns result valid.
// ----------------------------------------------------------------------------
module rmst_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic [rmst_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            s_tready,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  rmst_pkg::sts_t                  sts,
    output rmst_pkg::cmd_t                  cmd
);
    import rmst_pkg::*;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_SWEEP;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SWEEP: begin
                if (sts.sweep_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (s_tuser)
                        OP_CLEAR:  state_next = ST_SWEEP;
                        OP_UPDATE: if (sts.upd_ok) state_next = ST_UPD_LEAF;
                        OP_QUERY:  state_next = sts.qry_ok ? ST_QRY_FIRST : ST_QRY_DONE;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_UPD_LEAF:  state_next = ST_UPD_WALK;
            ST_UPD_WALK: begin
                if (sts.upd_root) state_next = ST_IDLE;
            end
            ST_QRY_FIRST: state_next = ST_QRY_WALK;
            ST_QRY_WALK: begin
                if (!sts.qry_more) state_next = ST_QRY_DONE;
            end
            ST_QRY_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_SWEEP: cmd.sweep_step = 1'b1;
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_upd = (s_tuser == OP_UPDATE);
                    cmd.load_qry = (s_tuser == OP_QUERY);
                end
            end
            ST_UPD_LEAF:  cmd.upd_leaf  = 1'b1;
            ST_UPD_WALK:  cmd.upd_walk  = 1'b1;
            ST_QRY_FIRST: cmd.qry_first = 1'b1;
            ST_QRY_WALK:  cmd.qry_walk  = 1'b1;
            ST_QRY_DONE:  cmd.out_load  = out_free;
            default:      cmd = '0;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) m_tvalid_next = 1'b0;
        if (cmd.out_load)             m_tvalid_next = 1'b1;
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// File: sv/rmst_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmst_datapath
// Node memory (one write, two registered reads), walk addresses, pair compare.
// ----------------------------------------------------------------------------
module rmst_datapath #(
    parameter int LEAVES     = rmst_pkg::LEAVES_DEF,
    parameter int VALUE_BITS = rmst_pkg::VALUE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [rmst_pkg::S_TDATA_W-1:0]  s_tdata,
    input  rmst_pkg::cmd_t                  cmd,
    output rmst_pkg::sts_t                  sts,
    output logic [rmst_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [rmst_pkg::M_TUSER_W-1:0]  m_tuser
);
    import rmst_pkg::*;

    localparam int LEAF_BITS = $clog2(LEAVES);
    localparam int ADDR_BITS = LEAF_BITS + 1;
    localparam int DEPTH     = 2 * LEAVES;
    // node word: {valid, value, index}; empty is all zero, so a plain
    // unsigned compare orders pairs by value then index
    localparam int NODE_W    = 1 + VALUE_BITS + POS_BITS;

    logic [NODE_W-1:0] mem [DEPTH];

    logic [POS_BITS-1:0]   in_pos, in_end;
    logic [VAL_W-1:0]      in_val;
    logic [LEAF_BITS-1:0]  pos_leaf, end_leaf;

    logic [ADDR_BITS-1:0]  a_reg, a_next, b_reg, b_next, sweep_reg, sweep_next;
    logic [NODE_W-1:0]     node_reg, node_next;
    logic [NODE_W-1:0]     rd_a_reg, rd_b_reg;
    logic                  take_a_reg, take_a_next, take_b_reg, take_b_next;
    logic                  found_reg;
    logic [VAL_W-1:0]      value_reg;
    logic [POS_BITS-1:0]   index_reg;

    logic                  we;
    logic [ADDR_BITS-1:0]  waddr, raddr_a, raddr_b;
    logic [NODE_W-1:0]     wdata, walk_max, cand_a, cand_b, qry_max;

    function automatic logic [NODE_W-1:0] pair_max(logic [NODE_W-1:0] p,
                                                   logic [NODE_W-1:0] q);
        return (q > p) ? q : p;
    endfunction

    assign in_pos = s_tdata[POS_BITS-1:0];
    assign in_end = s_tdata[2*POS_BITS-1:POS_BITS];
    assign in_val = s_tdata[2*POS_BITS+VAL_W-1:2*POS_BITS];

    assign pos_leaf = LEAF_BITS'(in_pos);
    assign end_leaf = (32'(in_end) >= LEAVES) ? '1 : LEAF_BITS'(in_end);

    assign sts.upd_ok     = 32'(in_pos) < LEAVES;
    assign sts.qry_ok     = (32'(in_pos) < LEAVES) && (end_leaf >= pos_leaf);
    assign sts.sweep_last = (sweep_reg == '1);
    assign sts.upd_root   = (a_reg[ADDR_BITS-1:1] == (ADDR_BITS-1)'(1));
    assign sts.qry_more   = (a_reg[ADDR_BITS-1:1] != b_reg[ADDR_BITS-1:1]);

    assign walk_max = pair_max(node_reg, rd_a_reg);
    assign cand_a   = take_a_reg ? rd_a_reg : '0;
    assign cand_b   = take_b_reg ? rd_b_reg : '0;
    assign qry_max  = pair_max(pair_max(node_reg, cand_a), cand_b);

    always_comb begin
        a_next      = a_reg;
        b_next      = b_reg;
        node_next   = node_reg;
        sweep_next  = sweep_reg;
        take_a_next = 1'b0;
        take_b_next = 1'b0;
        we          = 1'b0;
        waddr       = sweep_reg;
        wdata       = '0;
        raddr_a     = a_reg;
        raddr_b     = b_reg;

        if (cmd.sweep_step) begin
            we         = 1'b1;
            sweep_next = sweep_reg + 1'b1;  // wraps to zero after the last node
        end
        if (cmd.load_upd) begin
            a_next    = {1'b1, pos_leaf};
            node_next = {1'b1, VALUE_BITS'(in_val), in_pos};
        end
        if (cmd.load_qry) begin
            a_next    = {1'b1, pos_leaf};
            b_next    = {1'b1, end_leaf};
            node_next = '0;
        end
        if (cmd.upd_leaf) begin
            we      = 1'b1;
            waddr   = a_reg;
            wdata   = node_reg;
            raddr_a = a_reg ^ ADDR_BITS'(1);
        end
        if (cmd.upd_walk) begin
            we        = 1'b1;
            waddr     = a_reg >> 1;
            wdata     = walk_max;
            node_next = walk_max;
            a_next    = a_reg >> 1;
            raddr_a   = (a_reg >> 1) ^ ADDR_BITS'(1);
        end
        if (cmd.qry_first) begin
            take_a_next = 1'b1;
            take_b_next = 1'b1;
        end
        if (cmd.qry_walk) begin
            node_next = qry_max;
            if (sts.qry_more) begin
                raddr_a     = a_reg + 1'b1;
                raddr_b     = b_reg - 1'b1;
                take_a_next = !a_reg[0];
                take_b_next = b_reg[0];
                a_next      = a_reg >> 1;
                b_next      = b_reg >> 1;
            end
        end
    end

    // node memory
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rd_a_reg <= mem[raddr_a];
        rd_b_reg <= mem[raddr_b];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg  <= '0;
            take_a_reg <= 1'b0;
            take_b_reg <= 1'b0;
        end else begin
            sweep_reg  <= sweep_next;
            take_a_reg <= take_a_next;
            take_b_reg <= take_b_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        node_reg <= node_next;
        if (cmd.out_load) begin
            found_reg <= node_reg[NODE_W-1];
            value_reg <= VAL_W'(node_reg[POS_BITS +: VALUE_BITS]);
            index_reg <= node_reg[POS_BITS-1:0];
        end
    end

    assign m_tdata = {{(M_TDATA_W-VAL_W-POS_BITS){1'b0}}, index_reg, value_reg};
    assign m_tuser = found_reg;

endmodule

// File: sv/range_max_segment_tree.sv
`timescale 1ns / 1ps
// Update: accepted, then busy writing the leaf and each level up to the root (one tree level a cycle).
// Query: walks both range ends upward, then loads the result once the output
//   register is free; ready again the cycle after the result is loaded into it.
// Clear: writes all 2*LEAVES nodes (2048 by default), one node written per cycle.
// Reset: same clearing pass with s_tready low.
// Rate is set by the tree depth (one level a cycle), the one-node-a-cycle clear and result back-pressure.
// ----------------------------------------------------------------------------
// range_max_segment_tree
// Segment tree with point update and inclusive range maximum query.
// ----------------------------------------------------------------------------
module range_max_segment_tree #(
    parameter int LEAVES     = rmst_pkg::LEAVES_DEF,
    parameter int VALUE_BITS = rmst_pkg::VALUE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input beats
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rmst_pkg::S_TDATA_W-1:0]  s_tdata,  // position, range_end, leaf_value, pad
    input  logic [rmst_pkg::S_TUSER_W-1:0]  s_tuser,  // operation
    // result beats (queries only)
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rmst_pkg::M_TDATA_W-1:0]  m_tdata,  // max_value, max_position, pad
    output logic [rmst_pkg::M_TUSER_W-1:0]  m_tuser   // found
);
    import rmst_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Controller: clear sweep after reset and on a clear beat; an update walks
    // leaf to root, one level a cycle; a query walks both range ends upward,
    // pulling in at most two siblings a level.
    rmst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: node memory of 2*LEAVES words. Node 1 is the root; leaf p is
    // node LEAVES+p. Out-of-tree updates are dropped, reversed or out-of-tree
    // queries answer not found, and an over-long range end is clipped.
    rmst_datapath #(
        .LEAVES     (LEAVES),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .sts     (sts),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

// File: sv/rmst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmst_checker
// Port-level checks for the segment tree, bound to the top level.
// ----------------------------------------------------------------------------
module rmst_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [rmst_pkg::S_TUSER_W-1:0]  s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rmst_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [rmst_pkg::M_TUSER_W-1:0]  m_tuser
);
    import rmst_pkg::*;

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // not found reports zero value and position
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("empty result with nonzero payload");

    // clearing pass after reset blocks input
    a_reset_sweep: assert property (@(posedge aclk)
        $rose(aresetn) |-> !s_tready)
        else $error("input taken during clearing pass");

    // clear and query beats always leave the block busy next cycle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == OP_CLEAR || s_tuser == OP_QUERY)
        |=> !s_tready)
        else $error("ready right after clear or query");

endmodule

bind range_max_segment_tree rmst_checker u_rmst_checker (.*);
